FILE: hw/rtl/id3p_pkg.sv
package id3p_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [6:0] {
    PH_MAGIC   = 7'b0000001,
    PH_HDR     = 7'b0000010,
    PH_EXT     = 7'b0000100,
    PH_FHDR    = 7'b0001000,
    PH_PAYLOAD = 7'b0010000,
    PH_TAIL    = 7'b0100000,
    PH_SINK    = 7'b1000000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_TAG     = 2'd0,
    KIND_FRAME   = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_END     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_MAGIC    = 3'd1,
    ST_SHORT    = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_OVERRUN  = 3'd4
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] version;
    logic [15:0] flag_bits;
    logic [31:0] frame_id;
    logic [31:0] byte_size;
    logic [7:0]  payload;
    status_t     status;
    logic        run_end;
  } res_t;

  typedef struct packed {
    logic [1:0] vld;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    unique case (idx)
      2'd0:    m = 8'h49;
      2'd1:    m = 8'h44;
      default: m = 8'h33;
    endcase
    return m;
  endfunction

endpackage

FILE: hw/rtl/id3v2_tag_stream_parser.sv
// A byte sits in the input holding register; its results are then queued for the port.
// Throughput: one byte per cycle while the queue has room for two; the final byte of a
// run that also yields a frame, tag or payload result puts two results into the
// 4-entry result queue, which drains one per cycle while out_tready is high.
// Reset: synchronous, active-low rst_n clears the parse state, input holding
// register and result queue; the parser also returns to reset after each final byte.
module id3v2_tag_stream_parser (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] tag_byte
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // [15:0] version, [31:16] flag_bits,
                                   // [63:32] frame_id, [95:64] byte_size,
                                   // [103:96] payload, [106:104] status
  output logic [1:0]   out_tuser,  // [1:0] kind
  output logic         out_tlast
);
  import id3p_pkg::*;

  logic              hold_v_r;
  logic [7:0]        hold_byte_r;
  logic              hold_last_r;
  logic              go;
  logic              room;
  logic [QCNT_W-1:0] q_cnt;
  push_t             push;
  res_t              head;

  assign room      = (q_cnt <= QCNT_W'(QDEPTH - 2));
  assign go        = hold_v_r && room;
  assign in_tready = !hold_v_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      hold_v_r <= 1'b1;
    end else if (go) begin
      hold_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      hold_byte_r <= in_tdata;
      hold_last_r <= in_tlast;
    end
  end

  id3p_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (go),
    .tag_byte   (hold_byte_r),
    .final_byte (hold_last_r),
    .push       (push)
  );

  id3p_rq u_rq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (out_tready),
    .head_valid (out_tvalid),
    .head       (head),
    .count      (q_cnt)
  );

  assign out_tdata = {5'b00000, head.status, head.payload, head.byte_size,
                      head.frame_id, head.flag_bits, head.version};
  assign out_tuser = head.kind;
  assign out_tlast = head.run_end;

`ifndef ASSERT_OFF
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt <= QCNT_W'(QDEPTH))
    else $error("result queue count beyond depth");

  a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == KIND_END)))
    else $error("tlast does not match end status kind");

  a_hold_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_v_r && !go) |=> (hold_v_r && $stable(hold_byte_r)))
    else $error("held byte lost before processing");

  a_pair_ends: assert property (@(posedge clk) disable iff (!rst_n)
    push.vld[1] |-> (push.vld[0] && push.r1.run_end && !push.r0.run_end))
    else $error("second result of a byte is not the end status");
`endif

endmodule

FILE: hw/rtl/id3p_core.sv
module id3p_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [7:0]       tag_byte,
  input  logic             final_byte,
  output id3p_pkg::push_t  push
);
  import id3p_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [31:0] byte_index_r, byte_index_nxt;
  logic [3:0]  fs_r, fs_nxt;
  logic [15:0] version_r, version_nxt;
  logic [15:0] flags_r, flags_nxt;
  logic [31:0] frame_id_r, frame_id_nxt;
  logic [27:0] declared_r, declared_nxt;
  logic [31:0] area_r, area_nxt;
  logic [31:0] frame_left_r, frame_left_nxt;
  status_t     err_r, err_nxt;

  logic [31:0] ext_fl;
  logic [31:0] need_fl;
  logic [31:0] need_base;
  logic [33:0] diff;
  logic [31:0] fl_dec;
  logic [1:0]  magic_idx;
  logic        nf;
  logic        data_v;
  res_t        data_res;
  res_t        stat_res;
  status_t     st;

  assign ext_fl    = {frame_left_r[23:0], tag_byte};
  assign need_fl   = (phase_r == PH_EXT) ? ext_fl : frame_left_r;
  assign need_base = (phase_r == PH_EXT) ? {4'h0, declared_r} : area_r;
  assign diff      = {2'b00, need_base} - {2'b00, need_fl} - 34'd10;
  assign fl_dec    = frame_left_r - {31'h0, (frame_left_r != 32'h0)};
  assign magic_idx = (byte_index_r < 32'd3) ? byte_index_r[1:0] : 2'd2;

  always_comb begin
    phase_nxt      = phase_r;
    byte_index_nxt = byte_index_r;
    fs_nxt         = fs_r;
    version_nxt    = version_r;
    flags_nxt      = flags_r;
    frame_id_nxt   = frame_id_r;
    declared_nxt   = declared_r;
    area_nxt       = area_r;
    frame_left_nxt = frame_left_r;
    err_nxt        = err_r;
    nf             = 1'b0;
    data_v         = 1'b0;
    data_res       = '0;
    stat_res       = '0;
    st             = ST_OK;

    unique case (phase_r)
      PH_MAGIC: begin
        if (tag_byte != magic_byte(magic_idx)) begin
          err_nxt   = ST_MAGIC;
          phase_nxt = PH_SINK;
        end else if (magic_idx == 2'd2) begin
          phase_nxt = PH_HDR;
        end
      end
      PH_HDR: begin
        if (byte_index_r <= 32'd4) begin
          version_nxt = {version_r[7:0], tag_byte};
        end else if (byte_index_r == 32'd5) begin
          flags_nxt = {8'h00, tag_byte};
        end else begin
          declared_nxt = {declared_r[20:0], tag_byte[6:0]};
          if (byte_index_r >= 32'd9) begin
            data_v             = 1'b1;
            data_res.kind      = KIND_TAG;
            data_res.version   = version_r;
            data_res.flag_bits = flags_r;
            data_res.byte_size = {4'h0, declared_nxt};
            if (flags_r[6]) begin
              phase_nxt      = PH_EXT;
              fs_nxt         = 4'd0;
              frame_left_nxt = 32'h0;
            end else begin
              area_nxt = {4'h0, declared_nxt};
              nf       = 1'b1;
            end
          end
        end
      end
      PH_EXT: begin
        if (fs_r >= 4'd6) begin
          frame_left_nxt = ext_fl;
        end
        if (fs_r >= 4'd9) begin
          if (diff[33]) begin
            err_nxt   = ST_OVERRUN;
            phase_nxt = PH_SINK;
          end else begin
            area_nxt = diff[31:0];
            nf       = 1'b1;
          end
        end else begin
          fs_nxt = fs_r + 4'd1;
        end
      end
      PH_FHDR: begin
        if (fs_r == 4'd0) begin
          frame_id_nxt   = {24'h0, tag_byte};
          frame_left_nxt = 32'h0;
          flags_nxt      = 16'h0;
        end else if (fs_r < 4'd4) begin
          frame_id_nxt = {frame_id_r[23:0], tag_byte};
        end else if (fs_r < 4'd8) begin
          frame_left_nxt = ext_fl;
        end else begin
          flags_nxt = {flags_r[7:0], tag_byte};
        end
        if (fs_r >= 4'd9) begin
          if (diff[33]) begin
            err_nxt   = ST_OVERRUN;
            phase_nxt = PH_SINK;
          end else begin
            area_nxt           = diff[31:0];
            data_v             = 1'b1;
            data_res.kind      = KIND_FRAME;
            data_res.flag_bits = flags_nxt;
            data_res.frame_id  = frame_id_r;
            data_res.byte_size = frame_left_r;
            if (frame_left_r == 32'h0) begin
              nf = 1'b1;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end else begin
          fs_nxt = fs_r + 4'd1;
        end
      end
      PH_PAYLOAD: begin
        data_v           = 1'b1;
        data_res.kind    = KIND_PAYLOAD;
        data_res.payload = tag_byte;
        frame_left_nxt   = fl_dec;
        if (fl_dec == 32'h0) begin
          nf = 1'b1;
        end
      end
      PH_TAIL, PH_SINK: begin
      end
      default: begin
      end
    endcase

    if (nf) begin
      if (area_nxt == 32'h0) begin
        phase_nxt = PH_TAIL;
      end else begin
        phase_nxt = PH_FHDR;
        fs_nxt    = 4'd0;
      end
    end

    if (final_byte) begin
      if (byte_index_r <= 32'd9) begin
        st = ST_SHORT;
      end else if (err_nxt == ST_MAGIC) begin
        st = ST_MAGIC;
      end else if (byte_index_r != ({4'h0, declared_r} + 32'd9)) begin
        st = ST_MISMATCH;
      end else if ((err_nxt != ST_OK) || (phase_nxt != PH_TAIL)) begin
        st = ST_OVERRUN;
      end else begin
        st = ST_OK;
      end
      stat_res.kind    = KIND_END;
      stat_res.status  = st;
      stat_res.run_end = 1'b1;
      phase_nxt      = PH_MAGIC;
      byte_index_nxt = 32'h0;
      fs_nxt         = 4'd0;
      version_nxt    = 16'h0;
      flags_nxt      = 16'h0;
      frame_id_nxt   = 32'h0;
      declared_nxt   = 28'h0;
      area_nxt       = 32'h0;
      frame_left_nxt = 32'h0;
      err_nxt        = ST_OK;
    end else if (byte_index_r != 32'hFFFF_FFFF) begin
      byte_index_nxt = byte_index_r + 32'd1;
    end

    push = '0;
    if (go) begin
      if (data_v && final_byte) begin
        push.vld = 2'b11;
        push.r0  = data_res;
        push.r1  = stat_res;
      end else if (data_v) begin
        push.vld = 2'b01;
        push.r0  = data_res;
      end else if (final_byte) begin
        push.vld = 2'b01;
        push.r0  = stat_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_MAGIC;
      byte_index_r <= 32'h0;
      fs_r         <= 4'd0;
      version_r    <= 16'h0;
      flags_r      <= 16'h0;
      frame_id_r   <= 32'h0;
      declared_r   <= 28'h0;
      area_r       <= 32'h0;
      frame_left_r <= 32'h0;
      err_r        <= ST_OK;
    end else if (go) begin
      phase_r      <= phase_nxt;
      byte_index_r <= byte_index_nxt;
      fs_r         <= fs_nxt;
      version_r    <= version_nxt;
      flags_r      <= flags_nxt;
      frame_id_r   <= frame_id_nxt;
      declared_r   <= declared_nxt;
      area_r       <= area_nxt;
      frame_left_r <= frame_left_nxt;
      err_r        <= err_nxt;
    end
  end

endmodule

FILE: hw/rtl/id3p_rq.sv
module id3p_rq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  id3p_pkg::push_t               push,
  input  logic                          pop,
  output logic                          head_valid,
  output id3p_pkg::res_t                head,
  output logic [id3p_pkg::QCNT_W-1:0]   count
);
  import id3p_pkg::*;

  res_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [QCNT_W-1:0] npush;
  logic              pop_en;

  assign npush      = QCNT_W'(push.vld[0]) + QCNT_W'(push.vld[1]);
  assign pop_en     = pop && (cnt_r != '0);
  assign head_valid = (cnt_r != '0);
  assign head       = mem[rd_ptr_r];
  assign count      = cnt_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(npush);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop_en);
    cnt_nxt    = cnt_r + npush - QCNT_W'(pop_en);
  end

  always_ff @(posedge clk) begin
    if (push.vld[0]) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (push.vld[1]) begin
      mem[wr_ptr_r + QPTR_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: test/tb_id3v2_tag_stream_parser.sv
`timescale 1ns / 1ps

module tb_id3v2_tag_stream_parser;
  import id3p_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HDR_BYTES = 10;
  localparam int EXT_FLAG_BIT = 6;
  localparam logic [23:0] TAG_MAGIC = 24'h494433;

  typedef enum int {
    FLAW_NONE,
    FLAW_MAGIC,
    FLAW_CUT,
    FLAW_EXTRA,
    FLAW_FRAME_SIZE,
    FLAW_EXT_PAD
  } flaw_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'h00;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;

  id3v2_tag_stream_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  int send_idle_pct = 0;
  int stall_pct = 0;
  int error_count = 0;
  int cycle_count = 0;
  int bytes_sent = 0;
  int runs_sent = 0;
  int results_checked = 0;
  int status_count [0:4];

  res_t       expected_results [$];
  logic [7:0] run_bytes [$];
  logic [7:0] body_bytes [$];

  phase_t      p_phase;
  logic [31:0] p_index;
  logic [31:0] p_shift;
  logic [15:0] p_version;
  logic [15:0] p_flags;
  logic [31:0] p_id;
  logic [27:0] p_declared;
  logic [31:0] p_area;
  logic [31:0] p_left;
  status_t     p_error;

  task automatic reset_parser();
    p_phase    = PH_MAGIC;
    p_index    = '0;
    p_shift    = '0;
    p_version  = '0;
    p_flags    = '0;
    p_id       = '0;
    p_declared = '0;
    p_area     = '0;
    p_left     = '0;
    p_error    = ST_OK;
  endtask

  task automatic enter_next_frame();
    if (p_area == 0) begin
      p_phase = PH_TAIL;
    end else begin
      p_phase = PH_FHDR;
      p_shift = '0;
    end
  endtask

  function automatic res_t blank_result(input kind_t k);
    res_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic fin);
    res_t        r;
    logic [32:0] need;
    logic [32:0] count;
    int unsigned mi;
    status_t     st;
    case (p_phase)
      PH_MAGIC: begin
        mi = (p_index < 3) ? p_index : 2;
        if (b != TAG_MAGIC[(2 - mi) * 8 +: 8]) begin
          p_error = ST_MAGIC;
          p_phase = PH_SINK;
        end else if (mi == 2) begin
          p_phase = PH_HDR;
        end
      end
      PH_HDR: begin
        if (p_index <= 4) begin
          p_version = {p_version[7:0], b};
        end else if (p_index == 5) begin
          p_flags = {8'h00, b};
        end else begin
          p_declared = {p_declared[20:0], b[6:0]};
          if (p_index >= 9) begin
            r = blank_result(KIND_TAG);
            r.version   = p_version;
            r.flag_bits = p_flags;
            r.byte_size = {4'h0, p_declared};
            expected_results.push_back(r);
            if (p_flags[EXT_FLAG_BIT]) begin
              p_phase = PH_EXT;
              p_shift = '0;
              p_left  = '0;
            end else begin
              p_area = {4'h0, p_declared};
              enter_next_frame();
            end
          end
        end
      end
      PH_EXT: begin
        if (p_shift >= 6) p_left = {p_left[23:0], b};
        if (p_shift >= 9) begin
          need = 33'd10 + {1'b0, p_left};
          if (need > {5'b0, p_declared}) begin
            p_error = ST_OVERRUN;
            p_phase = PH_SINK;
          end else begin
            p_area = {4'h0, p_declared} - need[31:0];
            enter_next_frame();
          end
        end else begin
          p_shift++;
        end
      end
      PH_FHDR: begin
        if (p_shift == 0) begin
          p_id    = '0;
          p_left  = '0;
          p_flags = '0;
        end
        if (p_shift < 4) p_id = {p_id[23:0], b};
        else if (p_shift < 8) p_left = {p_left[23:0], b};
        else p_flags = {p_flags[7:0], b};
        if (p_shift >= 9) begin
          need = 33'd10 + {1'b0, p_left};
          if (need > {1'b0, p_area}) begin
            p_error = ST_OVERRUN;
            p_phase = PH_SINK;
          end else begin
            p_area = p_area - need[31:0];
            r = blank_result(KIND_FRAME);
            r.flag_bits = p_flags;
            r.frame_id  = p_id;
            r.byte_size = p_left;
            expected_results.push_back(r);
            if (p_left == 0) enter_next_frame();
            else p_phase = PH_PAYLOAD;
          end
        end else begin
          p_shift++;
        end
      end
      PH_PAYLOAD: begin
        r = blank_result(KIND_PAYLOAD);
        r.payload = b;
        expected_results.push_back(r);
        if (p_left != 0) p_left--;
        if (p_left == 0) enter_next_frame();
      end
      default: ;
    endcase

    if (fin) begin
      count = {1'b0, p_index} + 33'd1;
      if (count <= HDR_BYTES) st = ST_SHORT;
      else if (p_error == ST_MAGIC) st = ST_MAGIC;
      else if (count != {5'b0, p_declared} + HDR_BYTES) st = ST_MISMATCH;
      else if (p_error != ST_OK || p_phase != PH_TAIL) st = ST_OVERRUN;
      else st = ST_OK;
      r = blank_result(KIND_END);
      r.status  = st;
      r.run_end = 1'b1;
      expected_results.push_back(r);
      status_count[st]++;
      reset_parser();
    end else if (p_index != '1) begin
      p_index++;
    end
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < 40)
      $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, field, got,
               want);
    error_count++;
  endtask

  always @(negedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction, kind", out_tuser, 0);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_tuser != want.kind) report_mismatch("kind", out_tuser, want.kind);
        if (out_tdata[15:0] != want.version)
          report_mismatch("version", out_tdata[15:0], want.version);
        if (out_tdata[31:16] != want.flag_bits)
          report_mismatch("flag_bits", out_tdata[31:16], want.flag_bits);
        if (out_tdata[63:32] != want.frame_id)
          report_mismatch("frame_id", out_tdata[63:32], want.frame_id);
        if (out_tdata[95:64] != want.byte_size)
          report_mismatch("byte_size", out_tdata[95:64], want.byte_size);
        if (out_tdata[103:96] != want.payload)
          report_mismatch("payload", out_tdata[103:96], want.payload);
        if (out_tdata[106:104] != want.status)
          report_mismatch("status", out_tdata[106:104], want.status);
        if (out_tlast != want.run_end) report_mismatch("run_end", out_tlast, want.run_end);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("** id3v2_tag_stream_parser: FAILED **");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    parse_byte(b, fin);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_run();
    for (int i = 0; i < run_bytes.size(); i++)
      send_byte(run_bytes[i], i == run_bytes.size() - 1);
    runs_sent++;
    run_bytes.delete();
  endtask

  task automatic add_random_bytes(input int n);
    for (int i = 0; i < n; i++) run_bytes.push_back(8'($urandom_range(255)));
  endtask

  task automatic add_payload(input int n);
    for (int i = 0; i < n; i++) body_bytes.push_back(8'($urandom_range(255)));
  endtask

  task automatic add_ext_header(input logic [31:0] pad_field);
    add_payload(6);
    for (int i = 3; i >= 0; i--) body_bytes.push_back(pad_field[i * 8 +: 8]);
  endtask

  task automatic add_frame_header(input logic [31:0] id, input logic [31:0] size_field,
                                  input logic [15:0] flags);
    for (int i = 3; i >= 0; i--) body_bytes.push_back(id[i * 8 +: 8]);
    for (int i = 3; i >= 0; i--) body_bytes.push_back(size_field[i * 8 +: 8]);
    body_bytes.push_back(flags[15:8]);
    body_bytes.push_back(flags[7:0]);
  endtask

  // header first, then the pending body; top_bits land in bit 7 of the size bytes
  task automatic assemble_tag(input logic [15:0] ver, input logic [7:0] flags,
                              input logic [27:0] size, input logic [3:0] top_bits);
    run_bytes.push_back(TAG_MAGIC[23:16]);
    run_bytes.push_back(TAG_MAGIC[15:8]);
    run_bytes.push_back(TAG_MAGIC[7:0]);
    run_bytes.push_back(ver[15:8]);
    run_bytes.push_back(ver[7:0]);
    run_bytes.push_back(flags);
    run_bytes.push_back({top_bits[3], size[27:21]});
    run_bytes.push_back({top_bits[2], size[20:14]});
    run_bytes.push_back({top_bits[1], size[13:7]});
    run_bytes.push_back({top_bits[0], size[6:0]});
    foreach (body_bytes[i]) run_bytes.push_back(body_bytes[i]);
    body_bytes.delete();
  endtask

  task automatic test_short_runs();
    run_bytes.push_back(8'h00);
    send_run();
    assemble_tag(16'hFFFF, 8'hBF, 28'hFFFFFFF, 4'hF);
    send_run();
    assemble_tag(16'h0300, 8'h00, 28'd0, 4'h0);
    add_random_bytes(1);
    send_run();
  endtask

  task automatic test_bad_magic();
    run_bytes.push_back(TAG_MAGIC[23:16]);
    run_bytes.push_back(8'h58);
    run_bytes.push_back(TAG_MAGIC[7:0]);
    add_random_bytes(9);
    send_run();
    run_bytes.push_back(TAG_MAGIC[23:16]);
    run_bytes.push_back(TAG_MAGIC[15:8]);
    run_bytes.push_back(8'h34);
    add_random_bytes(8);
    send_run();
  endtask

  task automatic test_frame_walk();
    add_frame_header(32'h54495432, 32'd2, 16'hFFFF);
    body_bytes.push_back(8'h00);
    body_bytes.push_back(8'hFF);
    add_frame_header(32'h00000000, 32'd0, 16'h0000);
    assemble_tag(16'h0400, 8'h00, 28'(body_bytes.size()), 4'h0);
    send_run();
    add_frame_header(32'hFFFFFFFF, 32'd1, 16'h8000);
    body_bytes.push_back(8'h5A);
    assemble_tag(16'h0000, 8'h80, 28'(body_bytes.size()), 4'hA);
    send_run();
  endtask

  task automatic test_extended_header();
    add_ext_header(32'd3);
    add_frame_header(32'h434F4D4D, 32'd1, 16'h0040);
    add_payload(1);
    assemble_tag(16'h0300, 8'h40, 28'(body_bytes.size() + 3), 4'h0);
    add_random_bytes(3);
    send_run();
    add_ext_header(32'hFFFFFFFF);
    assemble_tag(16'h0401, 8'hFF, 28'(body_bytes.size() + 5), 4'h5);
    add_random_bytes(5);
    send_run();
  endtask

  task automatic test_overrun();
    add_frame_header(32'h50524956, 32'hFFFFFFFF, 16'h0000);
    add_payload(1);
    assemble_tag(16'h0300, 8'h00, 28'(body_bytes.size()), 4'h0);
    send_run();
    add_frame_header(32'h54414C42, 32'd4, 16'h1234);
    repeat (5) void'(body_bytes.pop_back());
    assemble_tag(16'h0300, 8'h00, 28'(body_bytes.size()), 4'h0);
    send_run();
  endtask

  task automatic test_size_mismatch();
    add_frame_header(32'h54504531, 32'd1, 16'h0000);
    add_payload(1);
    assemble_tag(16'h0300, 8'h00, 28'(body_bytes.size() + 1), 4'h0);
    send_run();
    add_frame_header(32'h54504532, 32'd1, 16'h0000);
    add_payload(1);
    assemble_tag(16'h0300, 8'h00, 28'(body_bytes.size()), 4'h0);
    add_random_bytes(1);
    send_run();
  endtask

  task automatic build_random_run();
    int          n;
    int          nframes;
    int          fsize;
    int          pad;
    int          tail;
    int          idx;
    flaw_t       flaw;
    bit          ext;
    logic [7:0]  flags;
    logic [31:0] size_field;
    logic [3:0]  top_bits;
    if ($urandom_range(99) < 8) begin
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
        if (i < 3 && $urandom_range(1)) run_bytes.push_back(TAG_MAGIC[(2 - i) * 8 +: 8]);
        else run_bytes.push_back(8'($urandom_range(255)));
      end
      return;
    end
    flaw = ($urandom_range(99) < 78) ? FLAW_NONE : flaw_t'($urandom_range(1, 5));
    ext = ($urandom_range(2) == 0) || (flaw == FLAW_EXT_PAD);
    flags = 8'($urandom_range(255));
    flags[EXT_FLAG_BIT] = ext;
    pad = $urandom_range(4);
    tail = ext ? pad : 0;
    if (ext) add_ext_header(flaw == FLAW_EXT_PAD ? $urandom : 32'(pad));
    nframes = $urandom_range(0, 3);
    if (flaw == FLAW_FRAME_SIZE && nframes == 0) nframes = 1;
    for (int f = 0; f < nframes; f++) begin
      if ($urandom_range(4) == 0) fsize = 0;
      else if ($urandom_range(9) == 0) fsize = $urandom_range(16, 40);
      else fsize = $urandom_range(1, 8);
      size_field = (flaw == FLAW_FRAME_SIZE && f == 0) ? $urandom : 32'(fsize);
      add_frame_header($urandom, size_field, 16'($urandom_range(65535)));
      add_payload(fsize);
    end
    top_bits = $urandom_range(1) ? 4'($urandom_range(15)) : 4'h0;
    assemble_tag(16'($urandom_range(65535)), flags, 28'(body_bytes.size() + tail), top_bits);
    add_random_bytes(tail);
    case (flaw)
      FLAW_MAGIC: begin
        idx = $urandom_range(2);
        run_bytes[idx] = run_bytes[idx] ^ (8'h01 << $urandom_range(7));
      end
      FLAW_CUT: repeat ($urandom_range(1, 3)) void'(run_bytes.pop_back());
      FLAW_EXTRA: add_random_bytes($urandom_range(1, 3));
      default: ;
    endcase
  endtask

  task automatic test_random_tags(input int byte_goal);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < byte_goal) begin
      build_random_run();
      send_run();
    end
  endtask

  initial begin
    reset_parser();
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_short_runs();
    test_bad_magic();
    test_frame_walk();
    test_extended_header();
    test_overrun();
    test_size_mismatch();

    send_idle_pct = 0;
    stall_pct = 0;
    test_random_tags(205);
    send_idle_pct = 67;
    stall_pct = 0;
    test_random_tags(205);
    send_idle_pct = 0;
    stall_pct = 67;
    test_random_tags(205);
    send_idle_pct = 12;
    stall_pct = 12;
    test_random_tags(205);

    in_tvalid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("checked %0d results from %0d tag runs (%0d bytes) under four idle/stall mixes",
             results_checked, runs_sent, bytes_sent);
    $display("end status: ok %0d, bad magic %0d, short %0d, mismatch %0d, overrun %0d",
             status_count[ST_OK], status_count[ST_MAGIC], status_count[ST_SHORT],
             status_count[ST_MISMATCH], status_count[ST_OVERRUN]);
    if (error_count == 0) begin
      $display("** id3v2_tag_stream_parser: PASSED **");
    end else begin
      $display("** id3v2_tag_stream_parser: FAILED **");
    end
    $finish;
  end

endmodule
